// ===== rtl/trv_pkg.sv =====
// Shared types and constants for the Trivium keystream XOR core.
// Used by trv_lane, trv_core and trivium_keystream_xor_core; no dependencies.
package trv_pkg;

   localparam int LEN_A     = 93;
   localparam int LEN_B     = 84;
   localparam int LEN_C     = 111;
   localparam int KEY_W     = 80;
   localparam int HALF_W    = 64;
   localparam int HIGH_W    = KEY_W - HALF_W;
   localparam int BYTE_W    = 8;
   localparam int NUM_LANES = BYTE_W;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;

   localparam logic OP_RESTART = 1'b0;
   localparam logic OP_CIPHER  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_LOW  = 2'd0,
      CSR_KEY_HIGH = 2'd1,
      CSR_IV_LOW   = 2'd2,
      CSR_IV_HIGH  = 2'd3
   } trv_csr_type;

   typedef enum logic {
      PH_IDLE = 1'b0,
      PH_WARM = 1'b1
   } trv_phase_type;

   typedef struct packed {
      logic [LEN_C-1:0] c;
      logic [LEN_B-1:0] b;
      logic [LEN_A-1:0] a;
   } trv_state_type;

   typedef struct packed {
      logic load;
      logic cipher;
   } trv_ctrl_type;

endpackage

// ===== rtl/trv_lane.sv =====
// One Trivium state update: next state and one keystream bit.
// Depends on trv_pkg.
module trv_lane (
   input  trv_pkg::trv_state_type st_cur,
   output trv_pkg::trv_state_type st_next,
   output logic                   ks_bit
);
   import trv_pkg::*;

   logic ta;
   logic tb;
   logic tc;

   always_comb begin
      ta     = st_cur.a[65] ^ st_cur.a[92];
      tb     = st_cur.b[68] ^ st_cur.b[83];
      tc     = st_cur.c[65] ^ st_cur.c[110];
      ks_bit = ta ^ tb ^ tc;
      st_next.a = {st_cur.a[LEN_A-2:0],
                   tc ^ (st_cur.c[108] & st_cur.c[109]) ^ st_cur.a[68]};
      st_next.b = {st_cur.b[LEN_B-2:0],
                   ta ^ (st_cur.a[90] & st_cur.a[91]) ^ st_cur.b[77]};
      st_next.c = {st_cur.c[LEN_C-2:0],
                   tb ^ (st_cur.b[81] & st_cur.b[82]) ^ st_cur.c[86]};
   end

endmodule

// ===== rtl/trv_core.sv =====
// Cipher state, eight chained update lanes, byte merge and warm-up sequencer.
// Depends on trv_pkg and trv_lane.
module trv_core #(
   parameter int WARMUP_STEPS = 1152
) (
   input  logic                        clock,
   input  logic                        reset,
   input  trv_pkg::trv_ctrl_type       ctrl,
   input  logic [trv_pkg::KEY_W-1:0]   key,
   input  logic [trv_pkg::KEY_W-1:0]   iv,
   input  logic [trv_pkg::BYTE_W-1:0]  data_byte,
   output logic [trv_pkg::BYTE_W-1:0]  out_byte,
   output logic                        busy
);
   import trv_pkg::*;

   localparam int CntW = $clog2(WARMUP_STEPS + 2);

   trv_phase_type phase_ff;
   trv_phase_type phase_in;
   trv_state_type st_ff;
   trv_state_type st_in;
   trv_state_type st_init;
   trv_state_type chain [NUM_LANES+1];
   logic [NUM_LANES-1:0] ks_bits;
   logic [BYTE_W-1:0]    ks_byte;
   logic [CntW-1:0]      rem_ff;
   logic [CntW-1:0]      rem_in;
   logic                 full_step;

   assign chain[0] = st_ff;

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      trv_lane u_lane (
         .st_cur  (chain[i]),
         .st_next (chain[i+1]),
         .ks_bit  (ks_bits[i])
      );
      assign ks_byte[BYTE_W-1-i] = ks_bits[i];
   end

   assign out_byte = data_byte ^ ks_byte;

   assign st_init.a = {{(LEN_A-KEY_W){1'b0}}, key};
   assign st_init.b = {{(LEN_B-KEY_W){1'b0}}, iv};
   assign st_init.c = {3'b111, {(LEN_C-3){1'b0}}};

   assign full_step = 32'(rem_ff) >= 32'(NUM_LANES);

   always_comb begin
      rem_in = rem_ff;
      st_in  = st_ff;
      if (ctrl.load) begin
         rem_in = CntW'(WARMUP_STEPS);
         st_in  = st_init;
      end else if (phase_ff == PH_WARM) begin
         if (full_step) begin
            rem_in = rem_ff - CntW'(NUM_LANES);
            st_in  = chain[NUM_LANES];
         end else begin
            rem_in = rem_ff - CntW'(1);
            st_in  = chain[1];
         end
      end else if (ctrl.cipher) begin
         st_in = chain[NUM_LANES];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (ctrl.load && WARMUP_STEPS != 0) begin
               phase_in = PH_WARM;
            end
         end
         PH_WARM: begin
            if (rem_in == '0) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_comb begin
      unique case (phase_ff)
         PH_IDLE: busy = 1'b0;
         PH_WARM: busy = 1'b1;
         default: busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         rem_ff   <= '0;
         st_ff    <= '0;
      end else begin
         phase_ff <= phase_in;
         rem_ff   <= rem_in;
         st_ff    <= st_in;
      end
   end

endmodule

// ===== rtl/trivium_keystream_xor_core.sv =====
// Top level of the Trivium keystream XOR block: key/IV registers, handshake
// and result register around trv_core. Depends on trv_pkg and trv_core.
//
//   channel  direction  transfer when          payload
//   req_*    in         req_valid & !req_stall req_op, req_data_byte
//   rsp_*    out        rsp_valid & !rsp_stall rsp_out_byte
//   csr_*    in         csr_we                 csr_index, csr_wdata
//
// A data byte passes through the eight chained update lanes and its result is
// registered in the cycle after it is accepted; a new byte transfers every
// cycle while the result register drains. A restart loads key and IV, then runs
// WARMUP_STEPS steps, eight per cycle while eight or more remain, else one per cycle;
// req_stall is high throughout. Reset (synchronous) clears state and keys.
// req_stall is also high while a result waits under rsp_stall.
module trivium_keystream_xor_core #(
   parameter int WARMUP_STEPS = 1152
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_op,
   input  logic [7:0]                      req_data_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   input  logic                            csr_we,
   input  logic [trv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [trv_pkg::CSR_W-1:0]       csr_wdata
);
   import trv_pkg::*;

   logic [HALF_W-1:0] key_low_ff;
   logic [HIGH_W-1:0] key_high_ff;
   logic [HALF_W-1:0] iv_low_ff;
   logic [HIGH_W-1:0] iv_high_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_out_byte_ff;
   logic [BYTE_W-1:0] core_byte;
   logic              busy;
   logic              accept;
   trv_ctrl_type      ctrl;

   assign req_stall    = busy | (rsp_valid_ff & rsp_stall);
   assign accept       = req_valid & ~req_stall;
   assign ctrl.load    = accept & (req_op == OP_RESTART);
   assign ctrl.cipher  = accept & (req_op == OP_CIPHER);
   assign rsp_valid_in = ctrl.cipher | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;

   trv_core #(
      .WARMUP_STEPS (WARMUP_STEPS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .key       ({key_high_ff, key_low_ff}),
      .iv        ({iv_high_ff, iv_low_ff}),
      .data_byte (req_data_byte),
      .out_byte  (core_byte),
      .busy      (busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
         iv_low_ff   <= '0;
         iv_high_ff  <= '0;
      end else if (csr_we) begin
         unique case (trv_csr_type'(csr_index))
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_KEY_HIGH: key_high_ff <= csr_wdata[HIGH_W-1:0];
            CSR_IV_LOW:   iv_low_ff   <= csr_wdata;
            CSR_IV_HIGH:  iv_high_ff  <= csr_wdata[HIGH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the byte until the transfer completes
   always_ff @(posedge clock) begin
      if (ctrl.cipher) begin
         rsp_out_byte_ff <= core_byte;
      end
   end

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for trivium_keystream_xor_core: directed table, then random
// key/IV phases with restarts and data bytes, checked against an in-bench cipher model.
// Depends on trv_pkg and the RTL of trivium_keystream_xor_core.
module tb;
   import trv_pkg::*;

   localparam int WARMUP_STEPS  = 1152;
   localparam int TOTAL_ITEMS   = 1050;
   localparam int SETTLE_CYCLES = WARMUP_STEPS / NUM_LANES + 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int PRINT_LIMIT   = 40;

   typedef enum logic [1:0] {
      KEYS_KEEP,
      KEYS_ZERO,
      KEYS_ONES,
      KEYS_ALT
   } keyset_type;

   typedef struct packed {
      keyset_type  keys;
      logic        op;
      logic [7:0]  data;
      logic        known;
      logic [7:0]  want;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_op;
   logic [7:0]           req_data_byte;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [7:0]           rsp_out_byte;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   logic [LEN_A-1:0]  st_a;
   logic [LEN_B-1:0]  st_b;
   logic [LEN_C-1:0]  st_c;
   logic [63:0]       key_low_q;
   logic [15:0]       key_high_q;
   logic [63:0]       iv_low_q;
   logic [15:0]       iv_high_q;

   logic [7:0]    want_bytes[$];
   stim_row_type  directed_rows [24];
   int            fail_count;
   int            items_sent;
   bit            sender_burst;
   bit            hold_off_req;

   trivium_keystream_xor_core #(
      .WARMUP_STEPS(WARMUP_STEPS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("MISMATCH at %0t: %s got %02h want %02h", $time, what, got, want);
   endtask

   function automatic logic trivium_step();
      logic ta, tb, tc, z;
      ta = st_a[65] ^ st_a[92];
      tb = st_b[68] ^ st_b[83];
      tc = st_c[65] ^ st_c[110];
      z  = ta ^ tb ^ tc;
      ta = ta ^ (st_a[90] & st_a[91]) ^ st_b[77];
      tb = tb ^ (st_b[81] & st_b[82]) ^ st_c[86];
      tc = tc ^ (st_c[108] & st_c[109]) ^ st_a[68];
      st_a = {st_a[LEN_A-2:0], tc};
      st_b = {st_b[LEN_B-2:0], ta};
      st_c = {st_c[LEN_C-2:0], tb};
      return z;
   endfunction

   function automatic logic [63:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 64'h0;
      if (r < 20) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_gap();
      int r;
      if (sender_burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic put_csr(input trv_csr_type idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_KEY_LOW:  key_low_q  = value;
         CSR_KEY_HIGH: key_high_q = value[15:0];
         CSR_IV_LOW:   iv_low_q   = value;
         CSR_IV_HIGH:  iv_high_q  = value[15:0];
      endcase
      @(posedge clock);
   endtask

   task automatic load_keys(input logic [3:0] mask, input logic [63:0] kl,
                            input logic [63:0] kh, input logic [63:0] il,
                            input logic [63:0] ih);
      if (mask[CSR_KEY_LOW])  put_csr(CSR_KEY_LOW, kl);
      if (mask[CSR_KEY_HIGH]) put_csr(CSR_KEY_HIGH, kh);
      if (mask[CSR_IV_LOW])   put_csr(CSR_IV_LOW, il);
      if (mask[CSR_IV_HIGH])  put_csr(CSR_IV_HIGH, ih);
      csr_we <= 1'b0;
   endtask

   // hold off until every result is back and any warm-up has run out
   task automatic settle();
      req_valid <= 1'b0;
      while (want_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(input logic op, input logic [7:0] data,
                            input logic known, input logic [7:0] want);
      int gap;
      logic [7:0] ks;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= data;
      do @(posedge clock); while (req_stall !== 1'b0);
      items_sent++;
      if (op == OP_RESTART) begin
         st_a = '0;
         st_b = '0;
         st_c = '0;
         st_a[KEY_W-1:0] = {key_high_q, key_low_q};
         st_b[KEY_W-1:0] = {iv_high_q, iv_low_q};
         st_c[LEN_C-1:LEN_C-3] = 3'b111;
         repeat (WARMUP_STEPS) void'(trivium_step());
      end else begin
         ks = '0;
         repeat (BYTE_W) ks = {ks[6:0], trivium_step()};
         want_bytes = {want_bytes, (known ? want : (data ^ ks))};
      end
   endtask

   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (want_bytes.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_out_byte, 8'h00);
         end else begin
            want = want_bytes.pop_front();
            if (rsp_out_byte !== want) report_mismatch("out_byte", rsp_out_byte, want);
         end
      end
   end

   initial begin
      int r, run, k;
      logic level;
      bit   mixed;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            r     = $urandom_range(0, 99);
            mixed = 1'b0;
            level = 1'b0;
            if (r < 40) begin
               run = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 20);
            end else if (r < 85) begin
               mixed = 1'b1;
               run   = $urandom_range(1, 20);
            end else begin
               level = 1'b1;
               run   = (r < 97) ? $urandom_range(1, 4) : $urandom_range(20, 60);
            end
            for (k = 0; k < run; k++) begin
               rsp_stall <= mixed ? ($urandom_range(0, 99) < 30) : level;
               @(posedge clock);
            end
         end
      end
   end

   initial begin
      int i, phase, count, waited, k;
      logic [3:0] mask;
      logic op;
      fail_count    = 0;
      items_sent    = 0;
      sender_burst  = 1'b0;
      hold_off_req  = 1'b0;
      st_a = '0;
      st_b = '0;
      st_c = '0;
      key_low_q  = '0;
      key_high_q = '0;
      iv_low_q   = '0;
      iv_high_q  = '0;
      directed_rows = '{
         '{KEYS_KEEP, OP_CIPHER,  8'h00, 1'b1, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'hFF, 1'b1, 8'hFF},
         '{KEYS_KEEP, OP_CIPHER,  8'h80, 1'b1, 8'h80},
         '{KEYS_KEEP, OP_CIPHER,  8'h01, 1'b1, 8'h01},
         '{KEYS_KEEP, OP_RESTART, 8'hFF, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'h00, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'hFF, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'h00, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'hA5, 1'b0, 8'h00},
         '{KEYS_ONES, OP_RESTART, 8'h00, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'h00, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'hFF, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'h3C, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_RESTART, 8'h5A, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_RESTART, 8'hA5, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'h00, 1'b0, 8'h00},
         '{KEYS_ALT,  OP_RESTART, 8'h00, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'h00, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'hFF, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'h96, 1'b0, 8'h00},
         '{KEYS_ZERO, OP_CIPHER,  8'h00, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'h7E, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_RESTART, 8'h00, 1'b0, 8'h00},
         '{KEYS_KEEP, OP_CIPHER,  8'h00, 1'b0, 8'h00}
      };

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_op        <= OP_CIPHER;
      req_data_byte <= 8'h00;
      csr_we        <= 1'b0;
      csr_index     <= CSR_KEY_LOW;
      csr_wdata     <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < 24; i++) begin
         if (directed_rows[i].keys != KEYS_KEEP) begin
            settle();
            case (directed_rows[i].keys)
               KEYS_ZERO: load_keys(4'hF, '0, '0, '0, '0);
               KEYS_ONES: load_keys(4'hF, '1, '1, '1, '1);
               default:   load_keys(4'hF, 64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_AAAA,
                                    64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0000_5555);
            endcase
         end
         send_item(directed_rows[i].op, directed_rows[i].data,
                   directed_rows[i].known, directed_rows[i].want);
      end

      phase = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 99) < 75) begin
            settle();
            mask = ($urandom_range(0, 99) < 70) ? 4'hF : 4'($urandom_range(1, 15));
            load_keys(mask, pick_word(), pick_word(), pick_word(), pick_word());
         end
         sender_burst = ($urandom_range(0, 99) < 25);
         if ($urandom_range(0, 99) < 85)
            send_item(OP_RESTART, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                             : $urandom_range(1, 40);
         if (phase == 4) begin
            sender_burst = 1'b1;
            hold_off_req = 1'b1;
            count        = 60;
         end
         for (k = 0; k < count; k++) begin
            op = ($urandom_range(0, 99) < 4) ? OP_RESTART : OP_CIPHER;
            send_item(op, ($urandom_range(0, 4) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                                      : 8'($urandom_range(0, 255)),
                      1'b0, 8'h00);
         end
         phase++;
      end

      req_valid <= 1'b0;
      for (waited = 0; want_bytes.size() != 0 && waited < DRAIN_LIMIT; waited++)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (want_bytes.size() != 0)
         report_mismatch("missing transfer", 8'h00, want_bytes[0]);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
